>>> design/x86dec_pkg.sv
package x86dec_pkg;

    // Instruction geometry
    localparam int STORE_DEPTH = 6;
    localparam int QUEUE_DEPTH = 2;

    // Opcode patterns (compared after masking)
    localparam logic [7:0] OPC_MOV_RM   = 8'b10001000;
    localparam logic [7:0] OPC_MOV_IMRM = 8'b11000110;
    localparam logic [7:0] OPC_MOV_IMRG = 8'b10110000;
    localparam logic [7:0] OPC_MOV_MACC = 8'b10100000;
    localparam logic [7:0] OPC_MOV_ACCM = 8'b10100010;
    localparam logic [7:0] OPC_ADD_RM   = 8'b00000000;
    localparam logic [7:0] OPC_SUB_RM   = 8'b00101000;
    localparam logic [7:0] OPC_CMP_RM   = 8'b00111000;
    localparam logic [7:0] OPC_ADD_IACC = 8'b00000100;
    localparam logic [7:0] OPC_SUB_IACC = 8'b00101100;
    localparam logic [7:0] OPC_CMP_IACC = 8'b00111100;
    localparam logic [7:0] OPC_GROUP    = 8'b10000000;

    localparam logic [7:0] MASK_TOP6 = 8'hFC;
    localparam logic [7:0] MASK_TOP7 = 8'hFE;
    localparam logic [7:0] MASK_TOP4 = 8'hF0;

    // Group 80..83 sub-operations
    localparam logic [2:0] GRP_ADD = 3'd0;
    localparam logic [2:0] GRP_SUB = 3'd5;
    localparam logic [2:0] GRP_CMP = 3'd7;

    // mod field codes and the direct-address rm
    localparam logic [1:0] MOD_MEM   = 2'd0;
    localparam logic [1:0] MOD_DISP8 = 2'd1;
    localparam logic [1:0] MOD_DISP16 = 2'd2;
    localparam logic [2:0] RM_ABS_ADDR = 3'h6;

    typedef enum logic [1:0] {
        OP_MOV = 2'd0,
        OP_ADD = 2'd1,
        OP_SUB = 2'd2,
        OP_CMP = 2'd3
    } op_kind_t;

    typedef enum logic [2:0] {
        FORM_RM_REG  = 3'd0,
        FORM_IMM_RM  = 3'd1,
        FORM_IMM_REG = 3'd2,
        FORM_MEM_ACC = 3'd3,
        FORM_ACC_MEM = 3'd4,
        FORM_IMM_ACC = 3'd5
    } form_t;

    typedef struct packed {
        logic     known;
        op_kind_t op;
        form_t    form;
    } class_t;

    // Raw instruction word handed from front to back
    typedef struct packed {
        logic [STORE_DEPTH-1:0][7:0] bytes;
        logic [2:0]                  len;
    } instr_t;

    // Decoded result word
    typedef struct packed {
        logic [1:0]  op_kind;
        logic [2:0]  form;
        logic        dir_bit;
        logic        wide;
        logic [1:0]  mode;
        logic [2:0]  reg_field;
        logic [2:0]  rm_field;
        logic [15:0] displacement;
        logic [15:0] value;
        logic [2:0]  length;
        logic        unknown;
    } result_t;

    // Opcode classification from the first byte
    function automatic class_t classify(input logic [7:0] b);
        class_t c;
        c.known = 1'b1;
        c.op    = OP_MOV;
        c.form  = FORM_RM_REG;
        if ((b & MASK_TOP6) == OPC_MOV_RM)
        begin
            c.op = OP_MOV; c.form = FORM_RM_REG;
        end
        else if ((b & MASK_TOP7) == OPC_MOV_IMRM)
        begin
            c.op = OP_MOV; c.form = FORM_IMM_RM;
        end
        else if ((b & MASK_TOP4) == OPC_MOV_IMRG)
        begin
            c.op = OP_MOV; c.form = FORM_IMM_REG;
        end
        else if ((b & MASK_TOP7) == OPC_MOV_MACC)
        begin
            c.op = OP_MOV; c.form = FORM_MEM_ACC;
        end
        else if ((b & MASK_TOP7) == OPC_MOV_ACCM)
        begin
            c.op = OP_MOV; c.form = FORM_ACC_MEM;
        end
        else if ((b & MASK_TOP6) == OPC_ADD_RM)
        begin
            c.op = OP_ADD; c.form = FORM_RM_REG;
        end
        else if ((b & MASK_TOP6) == OPC_SUB_RM)
        begin
            c.op = OP_SUB; c.form = FORM_RM_REG;
        end
        else if ((b & MASK_TOP6) == OPC_CMP_RM)
        begin
            c.op = OP_CMP; c.form = FORM_RM_REG;
        end
        else if ((b & MASK_TOP7) == OPC_ADD_IACC)
        begin
            c.op = OP_ADD; c.form = FORM_IMM_ACC;
        end
        else if ((b & MASK_TOP7) == OPC_SUB_IACC)
        begin
            c.op = OP_SUB; c.form = FORM_IMM_ACC;
        end
        else if ((b & MASK_TOP7) == OPC_CMP_IACC)
        begin
            c.op = OP_CMP; c.form = FORM_IMM_ACC;
        end
        else if ((b & MASK_TOP6) == OPC_GROUP)
        begin
            c.op = OP_MOV; c.form = FORM_IMM_RM;
        end
        else
        begin
            c.known = 1'b0;
        end
        return c;
    endfunction

    // Displacement bytes implied by a mod-reg-rm byte
    function automatic logic [1:0] disp_bytes(input logic [7:0] modrm);
        logic [1:0] n;
        n = 2'd0;
        if (modrm[7:6] == MOD_DISP8)
        begin
            n = 2'd1;
        end
        else if (modrm[7:6] == MOD_DISP16)
        begin
            n = 2'd2;
        end
        else if (modrm[7:6] == MOD_MEM && modrm[2:0] == RM_ABS_ADDR)
        begin
            n = 2'd2;
        end
        return n;
    endfunction

    // Immediate bytes of C6/C7 and the 80..83 group
    function automatic logic [1:0] imm_bytes(input logic [7:0] b0);
        logic [1:0] k;
        if ((b0 & MASK_TOP7) == OPC_MOV_IMRM)
        begin
            k = b0[0] ? 2'd2 : 2'd1;
        end
        else
        begin
            k = (!b0[1] && b0[0]) ? 2'd2 : 2'd1;
        end
        return k;
    endfunction

endpackage

>>> design/x86dec_front.sv
module x86dec_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [7:0]             in_byte,
    input  logic                   q_full,
    output logic                   q_push,
    output x86dec_pkg::instr_t     q_data
);
    import x86dec_pkg::*;

    logic [7:0] store_reg [STORE_DEPTH];
    logic [2:0] held_reg, held_next;
    logic [2:0] needed_reg, needed_next;

    logic       take;
    logic [7:0] b0;
    class_t     cls;
    logic       w;
    logic [2:0] need;
    logic [2:0] held_inc;

    assign take     = push && !q_full;
    assign b0       = (held_reg == 3'd0) ? in_byte : store_reg[0];
    assign cls      = classify(b0);
    assign w        = (cls.form == FORM_IMM_REG) ? b0[3] : b0[0];
    assign held_inc = held_reg + 3'd1;

    // Total length: known from the opcode, or from the mod-reg-rm byte
    always_comb
    begin
        if (needed_reg != 3'd0) begin
            need = needed_reg;
        end else begin
            need = 3'd2 + {1'b0, disp_bytes(in_byte)}
                 + ((cls.form == FORM_IMM_RM) ? {1'b0, imm_bytes(b0)} : 3'd0);
        end
    end

    // Completion and count update
    always_comb
    begin
        held_next   = held_reg;
        needed_next = needed_reg;
        q_push      = 1'b0;
        q_data.len  = need;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            q_data.bytes[i] = (held_reg == 3'(i)) ? in_byte : store_reg[i];
        end
        if (take) begin
            if (held_reg == 3'd0) begin
                if (!cls.known) begin
                    q_push      = 1'b1;
                    q_data.len  = 3'd1;
                    held_next   = 3'd0;
                    needed_next = 3'd0;
                end else begin
                    held_next = 3'd1;
                    case (cls.form)
                        FORM_IMM_REG, FORM_IMM_ACC: needed_next = 3'd2 + {2'b00, w};
                        FORM_MEM_ACC, FORM_ACC_MEM: needed_next = 3'd3;
                        default:                    needed_next = 3'd0;
                    endcase
                end
            end else if (held_inc == need) begin
                q_push      = 1'b1;
                held_next   = 3'd0;
                needed_next = 3'd0;
            end else begin
                held_next   = held_inc;
                needed_next = need;
            end
        end
    end

    // Count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_reg   <= 3'd0;
            needed_reg <= 3'd0;
        end else begin
            held_reg   <= held_next;
            needed_reg <= needed_next;
        end
    end

    // Byte buffer
    always_ff @(posedge clk)
    begin
        if (take) begin
            store_reg[held_reg] <= in_byte;
        end
    end

`ifndef SYNTHESIS
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= 3'd5)
        else $error("front: byte count beyond longest instruction");

    a_needed_valid: assert property (@(posedge clk) disable iff (!rst_n)
        needed_reg != 3'd1 && needed_reg <= 3'd6)
        else $error("front: bad pending length");
`endif

endmodule

>>> design/x86dec_queue.sv
module x86dec_queue #(
    parameter int DEPTH = x86dec_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  x86dec_pkg::instr_t     wdata,
    output logic                   full,
    input  logic                   pop,
    output logic                   valid,
    output x86dec_pkg::instr_t     rdata
);
    import x86dec_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    instr_t            mem_reg [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CntW'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(DEPTH))
        else $error("queue: occupancy beyond depth");
`endif

endmodule

>>> design/x86dec_back.sv
module x86dec_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  x86dec_pkg::instr_t     in_instr,
    output logic                   in_take,
    output logic                   empty,
    input  logic                   pop,
    output x86dec_pkg::result_t    result
);
    import x86dec_pkg::*;

    logic    valid_reg, valid_next;
    result_t result_reg;
    result_t dec;

    logic [7:0] b0, m;
    class_t     cls;
    logic [1:0] n;
    logic [1:0] k;
    logic [2:0] at;
    logic [7:0] ib;

    assign b0  = in_instr.bytes[0];
    assign m   = in_instr.bytes[1];
    assign cls = classify(b0);
    assign n   = disp_bytes(m);
    assign k   = imm_bytes(b0);
    assign at  = 3'd2 + {1'b0, n};
    assign ib  = in_instr.bytes[at];

    // Field extraction
    always_comb
    begin
        dec              = '0;
        dec.length       = in_instr.len;
        dec.unknown      = !cls.known;
        if (cls.known) begin
            dec.op_kind = cls.op;
            dec.form    = cls.form;
            dec.wide    = (cls.form == FORM_IMM_REG) ? b0[3] : b0[0];
            case (cls.form)
                FORM_RM_REG, FORM_IMM_RM:
                begin
                    dec.mode      = m[7:6];
                    dec.reg_field = m[5:3];
                    dec.rm_field  = m[2:0];
                    dec.dir_bit   = b0[1];
                    if (n == 2'd1) begin
                        dec.displacement = {{8{in_instr.bytes[2][7]}}, in_instr.bytes[2]};
                    end else if (n == 2'd2) begin
                        dec.displacement = {in_instr.bytes[3], in_instr.bytes[2]};
                    end
                    if (cls.form == FORM_IMM_RM) begin
                        if (k == 2'd2) begin
                            dec.value = {in_instr.bytes[at + 3'd1], ib};
                        end else if ((b0 & MASK_TOP6) == OPC_GROUP && b0[1:0] == 2'b11) begin
                            dec.value = {{8{ib[7]}}, ib};
                        end else begin
                            dec.value = {8'h00, ib};
                        end
                        if ((b0 & MASK_TOP6) == OPC_GROUP) begin
                            if (m[5:3] == GRP_ADD) begin
                                dec.op_kind = OP_ADD;
                            end else if (m[5:3] == GRP_SUB) begin
                                dec.op_kind = OP_SUB;
                            end else if (m[5:3] == GRP_CMP) begin
                                dec.op_kind = OP_CMP;
                            end else begin
                                dec.op_kind = OP_MOV;
                                dec.unknown = 1'b1;
                            end
                        end
                    end
                end
                FORM_IMM_REG, FORM_IMM_ACC:
                begin
                    if (cls.form == FORM_IMM_REG) begin
                        dec.reg_field = b0[2:0];
                    end
                    dec.value = dec.wide ? {in_instr.bytes[2], in_instr.bytes[1]}
                                         : {8'h00, in_instr.bytes[1]};
                end
                default:
                begin
                    dec.dir_bit = b0[1];
                    dec.value   = {in_instr.bytes[2], in_instr.bytes[1]};
                end
            endcase
        end
    end

    // Output register: refill when empty or being drained
    assign in_take = in_valid && (!valid_reg || pop);
    assign empty   = !valid_reg;
    assign result  = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_take) begin
            valid_next = 1'b1;
        end else if (pop) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            result_reg <= dec;
        end
    end

`ifndef SYNTHESIS
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (result_reg.length != 3'd0 && result_reg.length <= 3'd6))
        else $error("back: result length out of range");

    a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> $past(in_valid))
        else $error("back: result appeared without a queued word");
`endif

endmodule

>>> design/x86_16_mov_alu_instruction_decoder.sv
// With the output register free, the last byte of an instruction is queued, then the
//   result register loads its decode and empty falls.
// Throughput: one byte per cycle unless full; full rises only when the queue fills.
// Reset (rst_n, async, active low) clears the byte count, pending length, queue
//   pointers and output valid; the byte buffer and payload registers are not reset.
module x86_16_mov_alu_instruction_decoder #(
    parameter int QueueDepth = x86dec_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         in_byte,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         op_kind,
    output logic [2:0]         form,
    output logic               dir_bit,
    output logic               wide,
    output logic [1:0]         mode,
    output logic [2:0]         reg_field,
    output logic [2:0]         rm_field,
    output logic signed [15:0] displacement,
    output logic [15:0]        value,
    output logic [2:0]         length,
    output logic               unknown
);
    import x86dec_pkg::*;

    logic    q_push, q_full, q_valid, q_take;
    instr_t  q_wdata, q_rdata;
    result_t res;

    // Byte collector
    x86dec_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .in_byte (in_byte),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_wdata)
    );

    // Instruction queue
    x86dec_queue #(
        .DEPTH (QueueDepth)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_take),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    // Field decoder and result register
    x86dec_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_instr (q_rdata),
        .in_take  (q_take),
        .empty    (empty),
        .pop      (pop),
        .result   (res)
    );

    assign full         = q_full;
    assign op_kind      = res.op_kind;
    assign form         = res.form;
    assign dir_bit      = res.dir_bit;
    assign wide         = res.wide;
    assign mode         = res.mode;
    assign reg_field    = res.reg_field;
    assign rm_field     = res.rm_field;
    assign displacement = res.displacement;
    assign value        = res.value;
    assign length       = res.length;
    assign unknown      = res.unknown;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import x86dec_pkg::*;

    // Clock and DUT ports
    logic               clk = 1'b0;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [7:0]         in_byte;
    logic               empty;
    logic               pop;
    logic [1:0]         op_kind;
    logic [2:0]         form;
    logic               dir_bit;
    logic               wide;
    logic [1:0]         mode;
    logic [2:0]         reg_field;
    logic [2:0]         rm_field;
    logic signed [15:0] displacement;
    logic [15:0]        value;
    logic [2:0]         length;
    logic               unknown;

    // Decoder shadow state
    logic [7:0] instr_bytes [0:STORE_DEPTH-1];
    int         bytes_held = 0;
    int         bytes_needed = 0;

    // Decoded words still owed by the DUT, oldest first
    result_t    pending_decodes[$];

    // Run bookkeeping
    int         errors = 0;
    int         bytes_sent = 0;
    int         decodes_seen = 0;
    int         unknowns_seen = 0;
    bit         idle_on = 1'b1;
    int         hold_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    x86_16_mov_alu_instruction_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .in_byte      (in_byte),
        .empty        (empty),
        .pop          (pop),
        .op_kind      (op_kind),
        .form         (form),
        .dir_bit      (dir_bit),
        .wide         (wide),
        .mode         (mode),
        .reg_field    (reg_field),
        .rm_field     (rm_field),
        .displacement (displacement),
        .value        (value),
        .length       (length),
        .unknown      (unknown)
    );

    // Displacement bytes following a mod-reg-rm byte
    function automatic int disp_len(input logic [7:0] m);
        if (m[7:6] == MOD_DISP8)
            return 1;
        if (m[7:6] == MOD_DISP16 || (m[7:6] == MOD_MEM && m[2:0] == RM_ABS_ADDR))
            return 2;
        return 0;
    endfunction

    // Immediate bytes of C6/C7 and the 80..83 group
    function automatic int imm_len(input logic [7:0] opc);
        if ((opc & MASK_TOP7) == OPC_MOV_IMRM)
            return 1 + opc[0];
        return (!opc[1] && opc[0]) ? 2 : 1;
    endfunction

    // Shadow decoder: takes one byte, returns 1 with the decoded word when
    // that byte ends an instruction (or is an unmatched opcode)
    function automatic bit decode_byte(input logic [7:0] b, output result_t r);
        logic [7:0] opc;
        logic [7:0] m;
        op_kind_t   op;
        form_t      fm;
        bit         known;
        logic       w;
        int         n;
        int         at;

        r = '0;
        op = OP_MOV;
        fm = FORM_RM_REG;
        known = 1'b1;
        if (bytes_held < STORE_DEPTH)
            instr_bytes[bytes_held] = b;
        bytes_held++;
        opc = instr_bytes[0];

        // opcode class from the first byte
        if ((opc & MASK_TOP6) == OPC_MOV_RM)
            fm = FORM_RM_REG;
        else if ((opc & MASK_TOP7) == OPC_MOV_IMRM)
            fm = FORM_IMM_RM;
        else if ((opc & MASK_TOP4) == OPC_MOV_IMRG)
            fm = FORM_IMM_REG;
        else if ((opc & MASK_TOP7) == OPC_MOV_MACC)
            fm = FORM_MEM_ACC;
        else if ((opc & MASK_TOP7) == OPC_MOV_ACCM)
            fm = FORM_ACC_MEM;
        else if ((opc & MASK_TOP6) == OPC_ADD_RM)
            op = OP_ADD;
        else if ((opc & MASK_TOP6) == OPC_SUB_RM)
            op = OP_SUB;
        else if ((opc & MASK_TOP6) == OPC_CMP_RM)
            op = OP_CMP;
        else if ((opc & MASK_TOP7) == OPC_ADD_IACC)
        begin
            op = OP_ADD;
            fm = FORM_IMM_ACC;
        end
        else if ((opc & MASK_TOP7) == OPC_SUB_IACC)
        begin
            op = OP_SUB;
            fm = FORM_IMM_ACC;
        end
        else if ((opc & MASK_TOP7) == OPC_CMP_IACC)
        begin
            op = OP_CMP;
            fm = FORM_IMM_ACC;
        end
        else if ((opc & MASK_TOP6) == OPC_GROUP)
            fm = FORM_IMM_RM;
        else
            known = 1'b0;

        // unmatched opcode: one-byte word right away
        if (!known)
        begin
            r.length = 3'd1;
            r.unknown = 1'b1;
            bytes_held = 0;
            bytes_needed = 0;
            return 1'b1;
        end

        w = (fm == FORM_IMM_REG) ? opc[3] : opc[0];

        // length known from the opcode alone for the short forms
        if (bytes_held == 1)
        begin
            case (fm)
                FORM_IMM_REG, FORM_IMM_ACC: bytes_needed = 2 + w;
                FORM_MEM_ACC, FORM_ACC_MEM: bytes_needed = 3;
                default:                    bytes_needed = 0;
            endcase
            return 1'b0;
        end
        if (bytes_needed == 0)
            bytes_needed = 2 + disp_len(instr_bytes[1])
                         + ((fm == FORM_IMM_RM) ? imm_len(opc) : 0);
        if (bytes_held < bytes_needed)
            return 1'b0;

        r.op_kind = op;
        r.form = fm;
        r.wide = w;
        r.length = 3'(bytes_needed);
        case (fm)
            FORM_RM_REG, FORM_IMM_RM:
            begin
                m = instr_bytes[1];
                r.mode = m[7:6];
                r.reg_field = m[5:3];
                r.rm_field = m[2:0];
                r.dir_bit = opc[1];
                n = disp_len(m);
                if (n == 1)
                    r.displacement = {{8{instr_bytes[2][7]}}, instr_bytes[2]};
                else if (n == 2)
                    r.displacement = {instr_bytes[3], instr_bytes[2]};
                if (fm == FORM_IMM_RM)
                begin
                    at = 2 + n;
                    if (imm_len(opc) == 2)
                        r.value = {instr_bytes[at + 1], instr_bytes[at]};
                    else if ((opc & MASK_TOP6) == OPC_GROUP && opc[1:0] == 2'b11)
                        r.value = {{8{instr_bytes[at][7]}}, instr_bytes[at]};
                    else
                        r.value = {8'h00, instr_bytes[at]};
                    // group sub-operation from the reg field
                    if ((opc & MASK_TOP6) == OPC_GROUP)
                    begin
                        case (m[5:3])
                            GRP_ADD: r.op_kind = OP_ADD;
                            GRP_SUB: r.op_kind = OP_SUB;
                            GRP_CMP: r.op_kind = OP_CMP;
                            default:
                            begin
                                r.op_kind = OP_MOV;
                                r.unknown = 1'b1;
                            end
                        endcase
                    end
                end
            end
            FORM_IMM_REG, FORM_IMM_ACC:
            begin
                if (fm == FORM_IMM_REG)
                    r.reg_field = opc[2:0];
                r.value = w ? {instr_bytes[2], instr_bytes[1]} : {8'h00, instr_bytes[1]};
            end
            default:
            begin
                r.dir_bit = opc[1];
                r.value = {instr_bytes[2], instr_bytes[1]};
            end
        endcase
        bytes_held = 0;
        bytes_needed = 0;
        return 1'b1;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one byte, wait for it to be taken, record its decode
    task automatic send_word(input logic [7:0] b);
        int      gap;
        result_t r;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            in_byte <= 8'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push <= 1'b1;
        in_byte <= b;
        do @(posedge clk); while (full);
        bytes_sent++;
        if (decode_byte(b, r))
            pending_decodes.push_back(r);
    endtask

    // One well-formed instruction with random content
    task automatic send_random_instr();
        logic [7:0] opc;
        logic [7:0] modrm;
        bit         has_modrm;
        int         extra;
        modrm = 8'($urandom);
        if ($urandom_range(0, 5) == 0)
        begin
            modrm[7:6] = MOD_MEM;
            modrm[2:0] = RM_ABS_ADDR;
        end
        has_modrm = 1'b1;
        extra = 0;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                case ($urandom_range(0, 3))
                    0:       opc = OPC_MOV_RM;
                    1:       opc = OPC_ADD_RM;
                    2:       opc = OPC_SUB_RM;
                    default: opc = OPC_CMP_RM;
                endcase
                opc[1:0] = 2'($urandom);
                extra = disp_len(modrm);
            end
            3:
            begin
                opc = OPC_MOV_IMRM;
                opc[0] = 1'($urandom);
                extra = disp_len(modrm) + imm_len(opc);
            end
            4, 5:
            begin
                opc = OPC_GROUP;
                opc[1:0] = 2'($urandom);
                // mostly valid sub-operations
                case ($urandom_range(0, 3))
                    0:       modrm[5:3] = GRP_ADD;
                    1:       modrm[5:3] = GRP_SUB;
                    2:       modrm[5:3] = GRP_CMP;
                    default: ;
                endcase
                extra = disp_len(modrm) + imm_len(opc);
            end
            6:
            begin
                opc = OPC_MOV_IMRG;
                opc[3:0] = 4'($urandom);
                has_modrm = 1'b0;
                extra = 1 + opc[3];
            end
            7:
            begin
                opc = $urandom_range(0, 1) ? OPC_MOV_MACC : OPC_MOV_ACCM;
                opc[0] = 1'($urandom);
                has_modrm = 1'b0;
                extra = 2;
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       opc = OPC_ADD_IACC;
                    1:       opc = OPC_SUB_IACC;
                    default: opc = OPC_CMP_IACC;
                endcase
                opc[0] = 1'($urandom);
                has_modrm = 1'b0;
                extra = 1 + opc[0];
            end
        endcase
        send_word(opc);
        if (has_modrm)
            send_word(modrm);
        repeat (extra) send_word(8'($urandom));
    endtask

    // Field extremes, every op and form, and the odd encodings
    task automatic test_directed();
        logic [7:0] stream[$];
        stream = {
            8'h89, 8'hD8,                         // mov reg-reg, mod 3
            8'h8B, 8'h46, 8'h80,                  // mov, negative disp8
            8'h02, 8'h87, 8'h34, 8'h12,           // add, disp16
            8'h2A, 8'h06, 8'hFF, 8'hFF,           // sub, direct address
            8'h3B, 8'h00,                         // cmp, mod 0
            8'hC7, 8'h86, 8'h00, 8'h80, 8'hFF, 8'hFF, // mov imm16 to mem, longest
            8'hC6, 8'h38, 8'h7F,                  // C6 with nonzero reg field
            8'h83, 8'hC0, 8'h80,                  // group add, sign-extended imm
            8'h82, 8'hE8, 8'hFF,                  // opcode 82 behaves as 80
            8'h81, 8'h3E, 8'h34, 8'h12, 8'h78, 8'h56, // group cmp, direct, imm16
            8'h80, 8'hC8, 8'h01,                  // bad group sub-operation
            8'hB0, 8'h00, 8'hBF, 8'hFF, 8'hFF,    // mov imm to reg, byte and word
            8'hA1, 8'h00, 8'h00, 8'hA2, 8'hFF, 8'hFF, // accumulator moves
            8'h04, 8'hFF, 8'h3D, 8'h00, 8'h80, 8'h2C, 8'h55, // imm to accumulator
            8'hFF, 8'h06                          // unmatched opcodes
        };
        foreach (stream[i])
            send_word(stream[i]);
    endtask

    // Receiver holds off while the sender streams back to back
    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_cycles = 300;
        repeat (40) send_random_instr();
        idle_on = 1'b1;
    endtask

    // Mostly valid instructions, some stray bytes, idling toggled in stretches
    task automatic test_random(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 29) == 0)
                idle_on = !idle_on;
            if ($urandom_range(0, 99) < 85)
                send_random_instr();
            else
                send_word(8'($urandom));
        end
        idle_on = 1'b1;
    endtask

    // Stimulus
    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        in_byte = 8'h00;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random(300);

        @(negedge clk);
        push <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes; checked %0d decoded words, %0d flagged unknown.",
                 bytes_sent, decodes_seen, unknowns_seen);
        $display("Covered all forms, odd encodings, random idling and a full-queue stall.");
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Receiver: random pop stalls plus the requested long hold-off
    initial
    begin
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                pop <= 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // Compare each popped word with the oldest pending decode
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_decodes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none actual length %0d",
                         $time, length);
            end
            else
            begin
                want = pending_decodes.pop_front();
                decodes_seen++;
                if (want.unknown)
                    unknowns_seen++;
                check_field("op_kind", 16'(want.op_kind), 16'(op_kind));
                check_field("form", 16'(want.form), 16'(form));
                check_field("dir_bit", 16'(want.dir_bit), 16'(dir_bit));
                check_field("wide", 16'(want.wide), 16'(wide));
                check_field("mode", 16'(want.mode), 16'(mode));
                check_field("reg_field", 16'(want.reg_field), 16'(reg_field));
                check_field("rm_field", 16'(want.rm_field), 16'(rm_field));
                check_field("displacement", want.displacement, displacement);
                check_field("value", want.value, value);
                check_field("length", 16'(want.length), 16'(length));
                check_field("unknown", 16'(want.unknown), 16'(unknown));
            end
        end
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("%0t: timeout with %0d words outstanding", $time, pending_decodes.size());
        $display("tb_top: errors");
        $finish;
    end

endmodule
